@@ design/lasm_pkg.sv @@
`timescale 1ns / 1ps
package lasm_pkg;

	// Line capacity: a line holds at most LINE_MAX - 1 bytes.
	localparam int LINE_MAX = 32;
	localparam int ADDR_W   = $clog2(LINE_MAX);
	localparam int CNT_W    = $clog2(LINE_MAX + 1);

	// Command queue between the front and the back (power of two).
	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

	// Special characters.
	localparam logic [7:0] CH_CR  = 8'h0d;
	localparam logic [7:0] CH_LF  = 8'h0a;
	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_DEL = 8'h7f;
	localparam logic [7:0] CH_SP  = 8'h20;

	// Command codes produced by the classifier.
	localparam logic [1:0] OP_PORT = 2'd0;
	localparam logic [1:0] OP_END  = 2'd1;
	localparam logic [1:0] OP_RUB  = 2'd2;
	localparam logic [1:0] OP_CHAR = 2'd3;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] data;
	} cmd_t;

	// Fixed texts, packed into one table: overrun message with CR LF, then
	// the CR LF that opens a completed line, then the rubout sequence.
	localparam int TXT_LEN = 27;
	localparam int TXT_W   = $clog2(TXT_LEN);
	localparam logic [8*TXT_LEN-1:0] TEXT_ROM = {
		"error: line too long", CH_CR, CH_LF,
		CH_CR, CH_LF,
		CH_BS, CH_SP, CH_BS
	};
	localparam logic [TXT_W-1:0] TXT_OVR_FIRST  = TXT_W'(0);
	localparam logic [TXT_W-1:0] TXT_OVR_LAST   = TXT_W'(21);
	localparam logic [TXT_W-1:0] TXT_CRLF_FIRST = TXT_W'(22);
	localparam logic [TXT_W-1:0] TXT_CRLF_LAST  = TXT_W'(23);
	localparam logic [TXT_W-1:0] TXT_RUB_FIRST  = TXT_W'(24);
	localparam logic [TXT_W-1:0] TXT_RUB_LAST   = TXT_W'(26);

	function automatic logic [7:0] text_byte(input logic [TXT_W-1:0] idx);
		int pos;
		pos = TXT_LEN - 1 - int'(idx);
		return TEXT_ROM[8*pos +: 8];
	endfunction

endpackage

@@ design/lasm_front.sv @@
`timescale 1ns / 1ps
module lasm_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic                req_type,
	input  logic [7:0]          rx_byte,
	input  logic                dtr_level,
	output logic                cmd_valid,
	input  logic                cmd_ready,
	output lasm_pkg::cmd_t      cmd
);

	lasm_pkg::cmd_t                  cmd_in;
	lasm_pkg::cmd_t                  q_mem [lasm_pkg::CMDQ_DEPTH];
	logic [lasm_pkg::CMDQ_AW-1:0]    wr_ptr_q;
	logic [lasm_pkg::CMDQ_AW-1:0]    rd_ptr_q;
	logic [lasm_pkg::CMDQ_AW:0]      cnt_q;
	logic                            do_push;
	logic                            do_pop;

	// Sort each item into one of four commands.
	always_comb begin
		cmd_in.data = rx_byte;
		if (req_type) begin
			cmd_in.op   = lasm_pkg::OP_PORT;
			cmd_in.data = {7'b0, dtr_level};
		end else if (rx_byte inside {lasm_pkg::CH_CR, lasm_pkg::CH_LF}) begin
			cmd_in.op = lasm_pkg::OP_END;
		end else if (rx_byte inside {lasm_pkg::CH_BS, lasm_pkg::CH_DEL}) begin
			cmd_in.op = lasm_pkg::OP_RUB;
		end else begin
			cmd_in.op = lasm_pkg::OP_CHAR;
		end
	end

	assign full      = (cnt_q == (lasm_pkg::CMDQ_AW + 1)'(lasm_pkg::CMDQ_DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = q_mem[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			q_mem[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!do_push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ design/lasm_back.sv @@
`timescale 1ns / 1ps
module lasm_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                echo_en,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  lasm_pkg::cmd_t      cmd,
	output logic                empty,
	input  logic                pop,
	output logic [7:0]          out_byte,
	output logic                out_dest,
	output logic                out_last
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_TEXT = 2'd1;
	localparam logic [1:0] S_LINE = 2'd2;
	localparam logic [1:0] S_ECHO = 2'd3;

	logic [1:0]                    state_q;
	logic [lasm_pkg::CNT_W-1:0]    count_q;
	logic                          port_open_q;
	logic [lasm_pkg::CNT_W-1:0]    drain_len_q;
	logic [lasm_pkg::ADDR_W-1:0]   line_idx_q;
	logic [lasm_pkg::TXT_W-1:0]    txt_idx_q;
	logic [lasm_pkg::TXT_W-1:0]    txt_end_q;
	logic                          line_after_q;
	logic [7:0]                    ch_q;

	logic [7:0]                    store_mem [lasm_pkg::LINE_MAX];
	logic [7:0]                    rd_data_q;
	logic [lasm_pkg::ADDR_W-1:0]   rd_addr;
	logic                          store_we;

	logic                          out_valid_q;
	logic                          load_ok;
	logic                          dispatch;
	logic                          line_end;
	logic                          has_room;

	assign empty     = !out_valid_q;
	assign load_ok   = !out_valid_q || pop;
	assign cmd_ready = (state_q == S_IDLE);
	assign dispatch  = cmd_valid && cmd_ready;
	assign has_room  = (count_q < lasm_pkg::CNT_W'(lasm_pkg::LINE_MAX - 1));
	assign line_end  = ((lasm_pkg::CNT_W'(line_idx_q) + lasm_pkg::CNT_W'(1)) == drain_len_q);
	assign store_we  = dispatch && (cmd.op == lasm_pkg::OP_CHAR) && has_room;

	// The read address runs one byte ahead while the line drains, so the
	// registered read data is ready whenever the output register frees up.
	always_comb begin
		rd_addr = '0;
		if (state_q == S_LINE) begin
			if (load_ok && !line_end) begin
				rd_addr = line_idx_q + 1'b1;
			end else begin
				rd_addr = line_idx_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (store_we) begin
			store_mem[count_q[lasm_pkg::ADDR_W-1:0]] <= cmd.data;
		end
		rd_data_q <= store_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			port_open_q  <= 1'b0;
			drain_len_q  <= '0;
			line_idx_q   <= '0;
			txt_idx_q    <= '0;
			txt_end_q    <= '0;
			line_after_q <= 1'b0;
			ch_q         <= '0;
			out_valid_q  <= 1'b0;
			out_byte     <= '0;
			out_dest     <= 1'b0;
			out_last     <= 1'b0;
		end else begin
			if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (dispatch) begin
						case (cmd.op)
							lasm_pkg::OP_PORT: begin
								if (cmd.data[0] && !port_open_q) begin
									count_q <= '0;
								end
								port_open_q <= cmd.data[0];
							end
							lasm_pkg::OP_END: begin
								if (count_q != '0) begin
									drain_len_q <= count_q;
									line_idx_q  <= '0;
									count_q     <= '0;
									if (echo_en) begin
										txt_idx_q    <= lasm_pkg::TXT_CRLF_FIRST;
										txt_end_q    <= lasm_pkg::TXT_CRLF_LAST;
										line_after_q <= 1'b1;
										state_q      <= S_TEXT;
									end else begin
										state_q <= S_LINE;
									end
								end
							end
							lasm_pkg::OP_RUB: begin
								if (count_q != '0) begin
									count_q <= count_q - 1'b1;
									if (echo_en) begin
										txt_idx_q    <= lasm_pkg::TXT_RUB_FIRST;
										txt_end_q    <= lasm_pkg::TXT_RUB_LAST;
										line_after_q <= 1'b0;
										state_q      <= S_TEXT;
									end
								end
							end
							default: begin
								if (has_room) begin
									count_q <= count_q + 1'b1;
									if (echo_en) begin
										ch_q    <= cmd.data;
										state_q <= S_ECHO;
									end
								end else begin
									// Overrun drops the byte and the line.
									count_q      <= '0;
									txt_idx_q    <= lasm_pkg::TXT_OVR_FIRST;
									txt_end_q    <= lasm_pkg::TXT_OVR_LAST;
									line_after_q <= 1'b0;
									state_q      <= S_TEXT;
								end
							end
						endcase
					end
				end
				S_TEXT: begin
					if (load_ok) begin
						out_valid_q <= 1'b1;
						out_byte    <= lasm_pkg::text_byte(txt_idx_q);
						out_dest    <= 1'b0;
						out_last    <= (txt_idx_q == txt_end_q) && !line_after_q;
						if (txt_idx_q == txt_end_q) begin
							state_q <= line_after_q ? S_LINE : S_IDLE;
						end else begin
							txt_idx_q <= txt_idx_q + 1'b1;
						end
					end
				end
				S_LINE: begin
					if (load_ok) begin
						out_valid_q <= 1'b1;
						out_byte    <= rd_data_q;
						out_dest    <= 1'b1;
						out_last    <= line_end;
						if (line_end) begin
							state_q <= S_IDLE;
						end else begin
							line_idx_q <= line_idx_q + 1'b1;
						end
					end
				end
				S_ECHO: begin
					if (load_ok) begin
						out_valid_q <= 1'b1;
						out_byte    <= ch_q;
						out_dest    <= 1'b0;
						out_last    <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ design/line_assembler_with_rubout_unit.sv @@
`timescale 1ns / 1ps
// Channel  | Direction | Handshake               | Payload
// input    | in        | push / full             | req_type, rx_byte, dtr_level
// result   | out       | empty / pop             | out_byte, out_dest, out_last
// config   | in        | cfg_wr_en (no wait)     | cfg_wr_data (echo enable)
//
// The back end takes a command from the command queue only while idle and then
// emits its result bytes, taking no new command until its last byte is loaded;
// the longest result is a full line of 31 bytes behind the CR LF echo.
// Reset clears the counters and queues but not the line store, whose entries
// are read only below the fill count. A stalled result holds in the output
// register while the two-entry command queue fills; full rises when it is full.
module line_assembler_with_rubout_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        req_type,
	input  logic [7:0]  rx_byte,
	input  logic        dtr_level,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_byte,
	output logic        out_dest,
	output logic        out_last,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data
);

	// The echo enable register is written directly; it only changes while the block is
	// idle if the user keeps to that, as the block itself does not enforce it.
	logic           echo_q;
	logic           cmd_valid;
	logic           cmd_ready;
	lasm_pkg::cmd_t cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_q <= 1'b0;
		end else if (cfg_wr_en) begin
			echo_q <= cfg_wr_data;
		end
	end

	// Front end: classifies each item into a command and queues it.
	lasm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.req_type  (req_type),
		.rx_byte   (rx_byte),
		.dtr_level (dtr_level),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	// Back end: owns the line store, fill count and port state, and emits the
	// result bytes of each command through its output register.
	lasm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.echo_en   (echo_q),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.empty     (empty),
		.pop       (pop),
		.out_byte  (out_byte),
		.out_dest  (out_dest),
		.out_last  (out_last)
	);

endmodule

@@ design/lasm_checker.sv @@
`timescale 1ns / 1ps
module lasm_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       empty,
	input  logic       pop,
	input  logic [7:0] out_byte,
	input  logic       out_dest,
	input  logic       out_last
);

	// A waiting item holds until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(out_byte) && $stable(out_dest)
			&& $stable(out_last))
		else $error("result changed while stalled");

	// Within one burst the next item follows without a gap.
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !empty && !out_last |=> !empty)
		else $error("gap inside a result burst");

	// Once line bytes start, the burst stays on the command sink.
	a_sink_run: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !empty && out_dest && !out_last |=> out_dest)
		else $error("terminal byte inside a completed line");

	// Line endings and rubouts are never stored, so never reach the sink.
	a_sink_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && out_dest |-> out_byte != lasm_pkg::CH_CR
			&& out_byte != lasm_pkg::CH_LF && out_byte != lasm_pkg::CH_BS
			&& out_byte != lasm_pkg::CH_DEL)
		else $error("control byte sent to the command sink");

endmodule

bind line_assembler_with_rubout_unit lasm_checker u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.empty    (empty),
	.pop      (pop),
	.out_byte (out_byte),
	.out_dest (out_dest),
	.out_last (out_last)
);
